FILE: sv/hics_pkg.sv
// Package for the homogeneous in-circle sign core.
// Holds the fixed field width and the sign codes of the result.
// No dependencies.
package hics_pkg;

    // Width of every coordinate port.
    localparam int FIELD_BITS = 16;

    // Result sign, two's complement in two bits.
    typedef logic signed [1:0] t_sign;

    localparam t_sign SIGN_NEG  = 2'sb11;
    localparam t_sign SIGN_ZERO = 2'sb00;
    localparam t_sign SIGN_POS  = 2'sb01;

endpackage

FILE: sv/homogeneous_in_circle_sign_core.sv
// In-circle sign of four points given in homogeneous integer coordinates.
// Six-stage pipeline with per-stage valid bits; uses hics_pkg.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------
//   input   | i_valid / o_ready   | i_{a,b,c,d}_{w,x,y}, 16 bits signed each
//   output  | o_valid / i_ready   | o_circle_sign (2b signed), o_range_error
//
// One item enters per clock while o_ready is high; the stages are set
// by the multiplier chain:
// cross products, 2W x 2W products, sums, 32-bit-class partial products of
// the final 4W x 4W products, their recombination, and the compare.
// Reset clears only the stage valid bits; payload registers hold no reset.
// A stall on the output holds the last stage; earlier stages keep advancing
// into empty slots, so bubbles collapse and nothing is lost or repeated.
module homogeneous_in_circle_sign_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_a_w,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_a_x,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_a_y,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_b_w,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_b_x,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_b_y,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_c_w,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_c_x,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_c_y,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_d_w,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_d_x,
    input  logic signed [hics_pkg::FIELD_BITS-1:0] i_d_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output hics_pkg::t_sign                       o_circle_sign,
    output logic                                  o_range_error
);

    // Exact widths: with the most negative code excluded, a cross difference
    // fits in 2*CB bits, a u/v sum in 4*CB bits, and the final product in
    // 8*CB bits.
    localparam int CB = COORD_BITS;
    localparam int W1 = 2 * CB;
    localparam int W2 = 4 * CB;
    localparam int H  = W2 / 2;
    localparam int W3 = 2 * W2;
    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Handshake: each stage advances when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG:1] adv;

    always_comb begin
        adv[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[1];
    assign o_valid = r_vld[NSTG];

    always_comb begin
        n_vld[1] = adv[1] ? i_valid : r_vld[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: take the low CB bits, flag the most negative code, and form
    // the eight cross differences p1*q1 - p2*q2.
    // ------------------------------------------------------------------
    function automatic logic signed [W1-1:0] cross_diff(
        input logic signed [CB-1:0] p1,
        input logic signed [CB-1:0] q1,
        input logic signed [CB-1:0] p2,
        input logic signed [CB-1:0] q2
    );
        logic signed [W1-1:0] m1;
        logic signed [W1-1:0] m2;
        m1 = p1 * q1;
        m2 = p2 * q2;
        return m1 - m2;
    endfunction

    function automatic logic is_min(input logic signed [CB-1:0] v);
        return v == {1'b1, {(CB-1){1'b0}}};
    endfunction

    logic signed [CB-1:0] wa, xa, ya, wb, xb, yb, wc, xc, yc, wd, xd, yd;

    assign wa = i_a_w[CB-1:0];
    assign xa = i_a_x[CB-1:0];
    assign ya = i_a_y[CB-1:0];
    assign wb = i_b_w[CB-1:0];
    assign xb = i_b_x[CB-1:0];
    assign yb = i_b_y[CB-1:0];
    assign wc = i_c_w[CB-1:0];
    assign xc = i_c_x[CB-1:0];
    assign yc = i_c_y[CB-1:0];
    assign wd = i_d_w[CB-1:0];
    assign xd = i_d_x[CB-1:0];
    assign yd = i_d_y[CB-1:0];

    logic n_bad1;
    assign n_bad1 = is_min(wa) || is_min(xa) || is_min(ya) || is_min(wb)
                 || is_min(xb) || is_min(yb) || is_min(wc) || is_min(xc)
                 || is_min(yc) || is_min(wd) || is_min(xd) || is_min(yd);

    logic                 r_bad1;
    logic signed [W1-1:0] r_yda, r_xda, r_xbc, r_ybc, r_ydc, r_xdc, r_xba, r_yba;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_bad1 <= n_bad1;
            r_yda  <= cross_diff(yd, wa, ya, wd);
            r_xda  <= cross_diff(xd, wa, xa, wd);
            r_xbc  <= cross_diff(xb, wc, xc, wb);
            r_ybc  <= cross_diff(yb, wc, yc, wb);
            r_ydc  <= cross_diff(yd, wc, yc, wd);
            r_xdc  <= cross_diff(xd, wc, xc, wd);
            r_xba  <= cross_diff(xb, wa, xa, wb);
            r_yba  <= cross_diff(yb, wa, ya, wb);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: eight products of cross differences.
    // ------------------------------------------------------------------
    logic                 r_bad2;
    logic signed [W2-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_bad2 <= r_bad1;
            r_p0   <= r_yda * r_xbc;
            r_p1   <= r_xda * r_ybc;
            r_p2   <= r_xda * r_xbc;
            r_p3   <= r_yda * r_ybc;
            r_p4   <= r_ydc * r_xba;
            r_p5   <= r_xdc * r_yba;
            r_p6   <= r_xdc * r_xba;
            r_p7   <= r_ydc * r_yba;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the four u/v sums.
    // ------------------------------------------------------------------
    logic                 r_bad3;
    logic signed [W2-1:0] r_uda_bc, r_vda_bc, r_udc_ba, r_vdc_ba;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_bad3   <= r_bad2;
            r_uda_bc <= r_p0 + r_p1;
            r_vda_bc <= r_p2 - r_p3;
            r_udc_ba <= r_p4 + r_p5;
            r_vdc_ba <= r_p6 - r_p7;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: split each operand into a signed high half and an unsigned
    // low half and form the four partial products of A = uda_bc*vdc_ba and
    // B = udc_ba*vda_bc.
    // ------------------------------------------------------------------
    logic signed [H-1:0] ua_hi, va_hi, ub_hi, vb_hi;
    logic        [H-1:0] ua_lo, va_lo, ub_lo, vb_lo;

    assign ua_hi = r_uda_bc[W2-1:H];
    assign ua_lo = r_uda_bc[H-1:0];
    assign va_hi = r_vdc_ba[W2-1:H];
    assign va_lo = r_vdc_ba[H-1:0];
    assign ub_hi = r_udc_ba[W2-1:H];
    assign ub_lo = r_udc_ba[H-1:0];
    assign vb_hi = r_vda_bc[W2-1:H];
    assign vb_lo = r_vda_bc[H-1:0];

    logic                  r_bad4;
    logic signed [2*H-1:0] r_a_hh, r_b_hh;
    logic signed [2*H:0]   r_a_hl, r_a_lh, r_b_hl, r_b_lh;
    logic        [2*H-1:0] r_a_ll, r_b_ll;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_bad4 <= r_bad3;
            r_a_hh <= ua_hi * va_hi;
            r_a_hl <= ua_hi * $signed({1'b0, va_lo});
            r_a_lh <= $signed({1'b0, ua_lo}) * va_hi;
            r_a_ll <= ua_lo * va_lo;
            r_b_hh <= ub_hi * vb_hi;
            r_b_hl <= ub_hi * $signed({1'b0, vb_lo});
            r_b_lh <= $signed({1'b0, ub_lo}) * vb_hi;
            r_b_ll <= ub_lo * vb_lo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the partial products into the full A and B.
    // ------------------------------------------------------------------
    logic signed [W3-1:0] n_prod_a, n_prod_b;

    assign n_prod_a = (W3'(r_a_hh) << (2 * H))
                    + ((W3'(r_a_hl) + W3'(r_a_lh)) << H)
                    + W3'(r_a_ll);
    assign n_prod_b = (W3'(r_b_hh) << (2 * H))
                    + ((W3'(r_b_hl) + W3'(r_b_lh)) << H)
                    + W3'(r_b_ll);

    logic                 r_bad5;
    logic signed [W3-1:0] r_prod_a, r_prod_b;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_bad5   <= r_bad4;
            r_prod_a <= n_prod_a;
            r_prod_b <= n_prod_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: compare and register the result. Force the sign to zero on
    // an out-of-range coordinate.
    // ------------------------------------------------------------------
    hics_pkg::t_sign n_sign;

    always_comb begin
        if (r_bad5) begin
            n_sign = hics_pkg::SIGN_ZERO;
        end else if (r_prod_a > r_prod_b) begin
            n_sign = hics_pkg::SIGN_POS;
        end else if (r_prod_a < r_prod_b) begin
            n_sign = hics_pkg::SIGN_NEG;
        end else begin
            n_sign = hics_pkg::SIGN_ZERO;
        end
    end

    hics_pkg::t_sign r_sign;
    logic            r_err;

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_sign <= n_sign;
            r_err  <= r_bad5;
        end
    end

    assign o_circle_sign = r_sign;
    assign o_range_error = r_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_circle_sign == hics_pkg::SIGN_ZERO)
        else $error("range error delivered with nonzero sign");

    a_sign_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_circle_sign == hics_pkg::SIGN_NEG
                  || o_circle_sign == hics_pkg::SIGN_ZERO
                  || o_circle_sign == hics_pkg::SIGN_POS))
        else $error("sign code out of range");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG] |-> o_ready)
        else $error("input stalled while output register is empty");

    a_err_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && r_bad5 && adv[6] |=> o_valid && o_range_error)
        else $error("range error lost between last two stages");

endmodule
